[rtl/core/hdl_number_literal_scanner_unit_defines.svh]
// Assertion macros for the number literal scanner.
// No dependencies.
`ifndef HDL_NUMBER_LITERAL_SCANNER_UNIT_DEFINES_SVH
`define HDL_NUMBER_LITERAL_SCANNER_UNIT_DEFINES_SVH
// implication checked every clock, off during reset
`define NLS_ASSERT_IMP(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// next-cycle implication
`define NLS_ASSERT_NXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

[rtl/core/nls_pkg.sv]
// Types and constants for the number literal scanner.
// No dependencies.
package nls_pkg;
    localparam logic [3:0] P_IDLE = 4'd0;
    localparam logic [3:0] P_UU   = 4'd1;
    localparam logic [3:0] P_DIG  = 4'd2;
    localparam logic [3:0] P_WS   = 4'd3;
    localparam logic [3:0] P_APOS = 4'd4;
    localparam logic [3:0] P_SIGN = 4'd5;
    localparam logic [3:0] P_BASE = 4'd6;
    localparam logic [3:0] P_VAL  = 4'd7;
    localparam logic [3:0] P_DOT  = 4'd8;
    localparam logic [3:0] P_FRAC = 4'd9;
    localparam logic [3:0] P_EXP  = 4'd10;
    localparam logic [3:0] P_EXPS = 4'd11;
    localparam logic [3:0] P_EXPD = 4'd12;
    localparam logic [3:0] P_TS1  = 4'd13;
    localparam logic [3:0] P_TS2  = 4'd14;

    localparam logic [1:0] K_INT  = 2'd0;
    localparam logic [1:0] K_REAL = 2'd1;
    localparam logic [1:0] K_TIME = 2'd2;
    localparam logic [1:0] K_UU   = 2'd3;

    localparam int F_SPACE = 0;
    localparam int F_SIGN  = 1;
    localparam int F_MISS  = 2;
    localparam int F_UNDER = 3;
    localparam int F_ILL   = 4;
    localparam int F_XZ    = 5;

    // byte classes computed in the front end
    typedef struct packed {
        logic dig;
        logic alnum;
        logic sp;
        logic apos;
        logic dot;
        logic und;
        logic qm;
        logic pm;
        logic e;
        logic s;
        logic sfx;
        logic xz;
        logic bnd;
        logic base_ok;
        logic [1:0] base;
    } t_cls;

    typedef struct packed {
        logic [7:0] c;
        logic       start;
        logic       eos;
        t_cls       cls;
    } t_item;

    typedef struct packed {
        logic [1:0] kind;
        logic       based;
        logic [7:0] len;
        logic [5:0] err;
    } t_res;
endpackage

[rtl/core/nls_if.sv]
// Valid/ready channel interface with generic payload.
// Depends on nothing.
interface nls_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

[rtl/core/nls_front.sv]
// Front end: accepts bytes, classifies them, feeds a two-entry queue.
// Depends on nls_pkg and the assertion macro header.
`include "hdl_number_literal_scanner_unit_defines.svh"
module nls_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_char,
    input  logic                i_start,
    input  logic                i_eos,
    output logic                o_valid,
    input  logic                i_ready,
    output nls_pkg::t_item      o_item
);
    nls_pkg::t_item r_q [2];
    logic [1:0] r_cnt, n_cnt;
    logic       r_rd, r_wr;
    nls_pkg::t_item w_item;
    logic [7:0] c;
    logic push, pop;

    always_comb begin
        c = i_char;
        w_item.c = c;
        w_item.start = i_start;
        w_item.eos = i_eos;
        w_item.cls.dig = (c >= "0") && (c <= "9");
        w_item.cls.alnum = w_item.cls.dig || ((c >= "a") && (c <= "z"))
                           || ((c >= "A") && (c <= "Z"));
        w_item.cls.sp = (c == " ") || (c == 8'h09);
        w_item.cls.apos = (c == 8'h27);
        w_item.cls.dot = (c == ".");
        w_item.cls.und = (c == "_");
        w_item.cls.qm = (c == "?");
        w_item.cls.pm = (c == "+") || (c == "-");
        w_item.cls.e = (c == "e") || (c == "E");
        w_item.cls.s = (c == "s") || (c == "S");
        w_item.cls.sfx = (c == "m") || (c == "u") || (c == "n") || (c == "p")
                         || (c == "f") || (c == "s");
        w_item.cls.xz = (c == "x") || (c == "X") || (c == "z") || (c == "Z")
                        || (c == "?");
        w_item.cls.bnd = !w_item.cls.alnum && !w_item.cls.und;
        w_item.cls.base_ok = 1'b1;
        case (c)
            "b", "B": w_item.cls.base = 2'd0;
            "o", "O": w_item.cls.base = 2'd1;
            "d", "D": w_item.cls.base = 2'd2;
            "h", "H": w_item.cls.base = 2'd3;
            default: begin
                w_item.cls.base = 2'd0;
                w_item.cls.base_ok = 1'b0;
            end
        endcase
    end

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item = r_q[r_rd];
    assign push = i_valid && o_ready;
    assign pop = o_valid && i_ready;

    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) n_cnt = r_cnt + 2'd1;
        else if (pop && !push) n_cnt = r_cnt - 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd <= 1'b0;
            r_wr <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (push) r_wr <= ~r_wr;
            if (pop) r_rd <= ~r_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wr] <= w_item;
    end

    `NLS_ASSERT_IMP(a_no_ovf, i_clk, i_rst_n, r_cnt == 2'd2, !push)
    `NLS_ASSERT_IMP(a_cnt_rng, i_clk, i_rst_n, 1'b1, r_cnt != 2'd3)
    `NLS_ASSERT_NXT(a_ptr, i_clk, i_rst_n, r_cnt == 2'd0 && !push, r_rd == r_wr)
endmodule

[rtl/core/nls_back.sv]
// Back end: scan state machine, one byte per cycle unless a result waits on a stalled receiver, registered result.
// Depends on nls_pkg and the assertion macro header.
`include "hdl_number_literal_scanner_unit_defines.svh"
module nls_back #(
    parameter int MAX_LENGTH = 255
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  nls_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output nls_pkg::t_res  o_res
);
    localparam int LW = $clog2(MAX_LENGTH + 1);
    localparam logic [LW-1:0] LMAX = LW'(MAX_LENGTH);

    logic [3:0]    r_ph, n_ph;
    logic [LW-1:0] r_len, n_len, r_com, n_com;
    logic [1:0]    r_bk, n_bk, r_vdc, n_vdc;
    logic          r_xz, n_xz, r_sps, n_sps, r_real, n_real;
    logic [5:0]    r_err, n_err;
    logic          r_la_s, n_la_s;
    logic          r_ov, n_ov;
    nls_pkg::t_res r_res, n_res;
    logic          emit;
    logic [1:0]    e_kind;
    logic          e_based;
    logic [LW-1:0] e_len;
    logic          take;
    nls_pkg::t_cls k;
    logic [7:0]    c;
    logic          go, ill;

    assign o_ready = !r_ov || i_ready;
    assign go = i_valid && o_ready;
    assign o_valid = r_ov;
    assign o_res = r_res;

    function automatic logic [LW-1:0] inc(input logic [LW-1:0] v);
        inc = (v < LMAX) ? v + LW'(1) : v;
    endfunction

    always_comb begin
        k = i_item.cls;
        c = i_item.c;
        n_ph = r_ph; n_len = r_len; n_com = r_com; n_bk = r_bk; n_vdc = r_vdc;
        n_xz = r_xz; n_sps = r_sps; n_real = r_real; n_err = r_err;
        n_la_s = r_la_s;
        emit = 1'b0; e_kind = nls_pkg::K_INT; e_based = 1'b0; e_len = r_com;
        take = 1'b0; ill = 1'b0;
        if (go && (i_item.start || r_ph != nls_pkg::P_IDLE)) begin
            if (i_item.start) begin
                n_len = '0; n_com = '0; n_bk = 2'd0; n_vdc = 2'd0; n_xz = 1'b0;
                n_sps = 1'b0; n_err = '0; n_real = 1'b0; n_la_s = 1'b0;
                n_ph = k.apos ? nls_pkg::P_UU : nls_pkg::P_DIG;
            end
            if (i_item.start && k.apos) begin
                take = 1'b1;
            end else begin
                case (n_ph)
                    nls_pkg::P_UU: begin
                        take = 1'b1; emit = 1'b1; e_kind = nls_pkg::K_UU;
                    end
                    nls_pkg::P_DIG: begin
                        if (k.dig || k.und) begin take = 1'b1; n_com = inc(n_len); end
                        else if (k.sp) begin take = 1'b1; n_ph = nls_pkg::P_WS; end
                        else if (k.apos) begin take = 1'b1; n_ph = nls_pkg::P_APOS; end
                        else if (k.dot) begin take = 1'b1; n_ph = nls_pkg::P_DOT; end
                        else if (k.e) begin take = 1'b1; n_ph = nls_pkg::P_EXP; end
                        else if (k.sfx) begin
                            take = 1'b1; n_la_s = (c == "s"); n_ph = nls_pkg::P_TS1;
                        end else emit = 1'b1;
                    end
                    nls_pkg::P_WS: begin
                        if (k.sp) take = 1'b1;
                        else if (k.apos) begin take = 1'b1; n_ph = nls_pkg::P_APOS; end
                        else emit = 1'b1;
                    end
                    nls_pkg::P_APOS, nls_pkg::P_SIGN: begin
                        if (k.sp) begin n_sps = 1'b1; take = 1'b1; end
                        else if (n_ph == nls_pkg::P_APOS && k.s) begin
                            take = 1'b1; n_ph = nls_pkg::P_SIGN;
                        end else if (k.base_ok) begin
                            n_bk = k.base;
                            if (n_sps) n_err[nls_pkg::F_SPACE] = 1'b1;
                            take = 1'b1; n_ph = nls_pkg::P_BASE;
                        end else emit = 1'b1;
                    end
                    nls_pkg::P_BASE, nls_pkg::P_VAL: begin
                        if (n_ph == nls_pkg::P_BASE && k.sp) take = 1'b1;
                        else if (k.alnum || k.und || k.qm) begin
                            if (n_ph == nls_pkg::P_BASE && k.und)
                                n_err[nls_pkg::F_UNDER] = 1'b1;
                            if (!k.und) begin
                                if (n_vdc < 2'd2) n_vdc = n_vdc + 2'd1;
                                if (k.xz) n_xz = 1'b1;
                                else begin
                                    case (n_bk)
                                        2'd0: ill = !((c == "0") || (c == "1"));
                                        2'd1: ill = !((c >= "0") && (c <= "7"));
                                        2'd2: ill = !k.dig;
                                        default: ill = !(k.dig
                                            || ((c >= "a") && (c <= "f"))
                                            || ((c >= "A") && (c <= "F")));
                                    endcase
                                    if (ill) n_err[nls_pkg::F_ILL] = 1'b1;
                                end
                            end
                            take = 1'b1; n_ph = nls_pkg::P_VAL;
                        end else begin
                            if (n_ph == nls_pkg::P_BASE) begin
                                if (k.pm) n_err[nls_pkg::F_SIGN] = 1'b1;
                                else n_err[nls_pkg::F_MISS] = 1'b1;
                            end
                            emit = 1'b1; e_based = 1'b1;
                        end
                    end
                    nls_pkg::P_DOT: begin
                        if (k.dig) begin
                            take = 1'b1; n_com = inc(n_len); n_real = 1'b1;
                            n_ph = nls_pkg::P_FRAC;
                        end else emit = 1'b1;
                    end
                    nls_pkg::P_FRAC: begin
                        if (k.dig || k.und) begin take = 1'b1; n_com = inc(n_len); end
                        else if (k.e) begin take = 1'b1; n_ph = nls_pkg::P_EXP; end
                        else if (k.sfx) begin
                            take = 1'b1; n_la_s = (c == "s"); n_ph = nls_pkg::P_TS1;
                        end else emit = 1'b1;
                    end
                    nls_pkg::P_EXP, nls_pkg::P_EXPS: begin
                        if (n_ph == nls_pkg::P_EXP && k.pm) begin
                            take = 1'b1; n_ph = nls_pkg::P_EXPS;
                        end else if (k.dig) begin
                            take = 1'b1; n_com = inc(n_len); n_real = 1'b1;
                            n_ph = nls_pkg::P_EXPD;
                        end else emit = 1'b1;
                    end
                    nls_pkg::P_EXPD: begin
                        if (k.dig || k.und) begin take = 1'b1; n_com = inc(n_len); end
                        else emit = 1'b1;
                    end
                    nls_pkg::P_TS1: begin
                        if (!n_la_s && c == "s") begin take = 1'b1; n_ph = nls_pkg::P_TS2; end
                        else if (n_la_s && k.bnd) begin
                            emit = 1'b1; e_kind = nls_pkg::K_TIME;
                        end else emit = 1'b1;
                    end
                    nls_pkg::P_TS2: begin
                        emit = 1'b1;
                        if (k.bnd) e_kind = nls_pkg::K_TIME;
                    end
                    default: n_ph = nls_pkg::P_IDLE;
                endcase
            end
            if (take) n_len = inc(n_len);
            // end of source closes a still-open token
            if (!emit && i_item.eos && n_ph != nls_pkg::P_IDLE) begin
                emit = 1'b1;
                case (n_ph)
                    nls_pkg::P_UU: e_kind = nls_pkg::K_UU;
                    nls_pkg::P_TS1: if (n_la_s) e_kind = nls_pkg::K_TIME;
                    nls_pkg::P_TS2: e_kind = nls_pkg::K_TIME;
                    nls_pkg::P_BASE: begin
                        n_err[nls_pkg::F_MISS] = 1'b1; e_based = 1'b1;
                    end
                    nls_pkg::P_VAL: e_based = 1'b1;
                    default: e_kind = nls_pkg::K_INT;
                endcase
            end
            if (emit) begin
                n_ph = nls_pkg::P_IDLE;
                if (e_based) begin
                    if (n_bk == 2'd2 && n_xz && n_vdc > 2'd1) n_err[nls_pkg::F_XZ] = 1'b1;
                    e_kind = nls_pkg::K_INT;
                end
                if (e_kind == nls_pkg::K_INT && !e_based) begin
                    e_kind = n_real ? nls_pkg::K_REAL : nls_pkg::K_INT;
                end
                e_len = (e_kind == nls_pkg::K_UU || e_kind == nls_pkg::K_TIME || e_based)
                        ? n_len : n_com;
            end
        end
        n_res = r_res;
        n_ov = r_ov && !i_ready;
        if (emit) begin
            n_ov = 1'b1;
            n_res.kind = e_kind;
            n_res.based = e_based;
            n_res.len = (32'(e_len) > 32'd255) ? 8'd255 : 8'(e_len);
            n_res.err = e_based ? n_err : 6'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= nls_pkg::P_IDLE; r_len <= '0; r_com <= '0; r_bk <= 2'd0;
            r_vdc <= 2'd0; r_xz <= 1'b0; r_sps <= 1'b0; r_real <= 1'b0;
            r_err <= '0; r_ov <= 1'b0;
        end else begin
            r_ph <= n_ph; r_len <= n_len; r_com <= n_com; r_bk <= n_bk;
            r_vdc <= n_vdc; r_xz <= n_xz; r_sps <= n_sps; r_real <= n_real;
            r_err <= n_err; r_ov <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_la_s <= n_la_s;
        r_res <= n_res;
    end

    `NLS_ASSERT_IMP(a_com_le_len, i_clk, i_rst_n, 1'b1, r_com <= r_len)
    `NLS_ASSERT_IMP(a_err_based, i_clk, i_rst_n, r_ov && !r_res.based, r_res.err == 6'd0)
    `NLS_ASSERT_NXT(a_hold, i_clk, i_rst_n, r_ov && !i_ready, r_ov && $stable(r_res))
endmodule

[rtl/core/hdl_number_literal_scanner_unit.sv]
// Number literal scanner: one source byte in, one token result out.
// Channels: in (char, start, end of source) and out (kind, length, errors),
// both valid/ready; a transfer happens when valid and ready are high.
// A front stage classifies each byte into a two-entry queue; the back
// stage runs the scan state machine, one byte per cycle while no result
// waits on a stalled receiver, and registers the result. The result of
// the byte that ends a token passes the queue register, then the result
// register, before it is valid.
// A byte ends a token when it cannot continue it, or when end_of_source
// is set. At most one result is produced per token; bytes seen while idle
// without the start bit are dropped, and a new start bit abandons any
// token in progress silently.
// When the receiver stalls, the result register holds and the back stage
// takes no byte while a result waits; the queue then fills and the input
// ready drops. Reset (synchronous, active low) empties the queue, drops
// any pending result and returns the scanner to idle.
// Lengths saturate at MAX_LENGTH and the reported length at 255.
module hdl_number_literal_scanner_unit #(
    parameter int MAX_LENGTH = 255
) (
    input logic i_clk,
    input logic i_rst_n,
    nls_if.sink   in_ch,
    nls_if.source out_ch
);
    logic           w_q_valid, w_q_ready;
    nls_pkg::t_item w_q_item;

    nls_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_ch.valid),
        .o_ready (in_ch.ready),
        .i_char  (in_ch.data.c),
        .i_start (in_ch.data.start),
        .i_eos   (in_ch.data.eos),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_item  (w_q_item)
    );

    nls_back #(.MAX_LENGTH(MAX_LENGTH)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .o_ready (w_q_ready),
        .i_item  (w_q_item),
        .o_valid (out_ch.valid),
        .i_ready (out_ch.ready),
        .o_res   (out_ch.data)
    );
endmodule

[test/nls_scoreboard.sv]
`timescale 1ns / 100ps
// Scoreboard for the number literal scanner: predicts each token result from
// the byte transfers and compares the result transfers. Depends on nls_pkg, nls_if.
module nls_scoreboard (
    input  logic i_clk,
    input  logic i_rst_n,
    nls_if       mon_in,
    nls_if       mon_out,
    output int   o_mismatches,
    output int   o_outstanding
);
    localparam int MAX_LEN = 255;

    logic [3:0]    phase;
    int            tok_len, sure_len;
    logic [1:0]    radix;
    logic [7:0]    sfx0;
    int            val_cnt;
    bit            had_xz, had_space, had_real;
    logic [5:0]    flags;
    bit            produced;
    nls_pkg::t_res next_res;
    nls_pkg::t_res expected_tokens[$];

    function automatic bit c_dig(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction
    function automatic bit c_alnum(logic [7:0] c);
        return c_dig(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction
    function automatic bit c_sp(logic [7:0] c);
        return c == " " || c == 8'h09;
    endfunction
    function automatic bit c_bnd(logic [7:0] c);
        return !c_alnum(c) && c != "_";
    endfunction
    function automatic bit c_xz(logic [7:0] c);
        return c == "x" || c == "X" || c == "z" || c == "Z" || c == "?";
    endfunction

    function void clear_token();
        tok_len = 0; sure_len = 0; radix = 0; sfx0 = 0; val_cnt = 0;
        had_xz = 0; had_space = 0; had_real = 0; flags = 0;
    endfunction

    function void take();
        if (tok_len < MAX_LEN) tok_len++;
    endfunction

    function void take_sure();
        take();
        sure_len = tok_len;
    endfunction

    function void post(logic [1:0] kind, bit based, int len);
        next_res.kind  = kind;
        next_res.based = based;
        next_res.len   = (len > 255) ? 8'd255 : len[7:0];
        next_res.err   = based ? flags : 6'd0;
        produced = 1;
        phase = nls_pkg::P_IDLE;
    endfunction

    function void post_plain();
        post(had_real ? nls_pkg::K_REAL : nls_pkg::K_INT, 0, sure_len);
    endfunction

    // decimal x/z only flagged when mixed with other value digits
    function void post_based();
        if (radix == 2'd2 && had_xz && val_cnt > 1) flags[nls_pkg::F_XZ] = 1;
        post(nls_pkg::K_INT, 1, tok_len);
    endfunction

    function void value_char(logic [7:0] c);
        bit ok;
        if (c == "_") return;
        if (val_cnt < 2) val_cnt++;
        if (c_xz(c)) begin
            had_xz = 1;
            return;
        end
        case (radix)
            2'd0: ok = (c == "0" || c == "1");
            2'd1: ok = (c >= "0" && c <= "7");
            2'd2: ok = c_dig(c);
            default: ok = c_dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
        endcase
        if (!ok) flags[nls_pkg::F_ILL] = 1;
    endfunction

    function void tail_suffix(logic [7:0] c);
        if (c == "m" || c == "u" || c == "n" || c == "p" || c == "f" || c == "s") begin
            sfx0 = c;
            take();
            phase = nls_pkg::P_TS1;
        end else begin
            post_plain();
        end
    endfunction

    function void tail_exp(logic [7:0] c);
        if (c == "e" || c == "E") begin
            take();
            phase = nls_pkg::P_EXP;
        end else begin
            tail_suffix(c);
        end
    endfunction

    function bit take_radix(logic [7:0] c);
        case (c)
            "b", "B": radix = 2'd0;
            "o", "O": radix = 2'd1;
            "d", "D": radix = 2'd2;
            "h", "H": radix = 2'd3;
            default: return 0;
        endcase
        if (had_space) flags[nls_pkg::F_SPACE] = 1;
        take();
        phase = nls_pkg::P_BASE;
        return 1;
    endfunction

    function void scan_byte(logic [7:0] c);
        case (phase)
            nls_pkg::P_UU: begin
                take();
                post(nls_pkg::K_UU, 0, tok_len);
            end
            nls_pkg::P_DIG: begin
                if (c_dig(c) || c == "_") take_sure();
                else if (c_sp(c)) begin take(); phase = nls_pkg::P_WS; end
                else if (c == "'") begin take(); phase = nls_pkg::P_APOS; end
                else if (c == ".") begin take(); phase = nls_pkg::P_DOT; end
                else tail_exp(c);
            end
            nls_pkg::P_WS: begin
                if (c_sp(c)) take();
                else if (c == "'") begin take(); phase = nls_pkg::P_APOS; end
                else post_plain();
            end
            nls_pkg::P_APOS: begin
                if (c_sp(c)) begin had_space = 1; take(); end
                else if (c == "s" || c == "S") begin take(); phase = nls_pkg::P_SIGN; end
                else if (!take_radix(c)) post_plain();
            end
            nls_pkg::P_SIGN: begin
                if (c_sp(c)) begin had_space = 1; take(); end
                else if (!take_radix(c)) post_plain();
            end
            nls_pkg::P_BASE: begin
                if (c_sp(c)) take();
                else if (c_alnum(c) || c == "_" || c == "?") begin
                    if (c == "_") flags[nls_pkg::F_UNDER] = 1;
                    value_char(c);
                    take();
                    phase = nls_pkg::P_VAL;
                end else begin
                    if (c == "+" || c == "-") flags[nls_pkg::F_SIGN] = 1;
                    else flags[nls_pkg::F_MISS] = 1;
                    post_based();
                end
            end
            nls_pkg::P_VAL: begin
                if (c_alnum(c) || c == "_" || c == "?") begin value_char(c); take(); end
                else post_based();
            end
            nls_pkg::P_DOT: begin
                if (c_dig(c)) begin
                    take_sure(); had_real = 1; phase = nls_pkg::P_FRAC;
                end else post_plain();
            end
            nls_pkg::P_FRAC: begin
                if (c_dig(c) || c == "_") take_sure();
                else tail_exp(c);
            end
            nls_pkg::P_EXP: begin
                if (c == "+" || c == "-") begin take(); phase = nls_pkg::P_EXPS; end
                else if (c_dig(c)) begin
                    take_sure(); had_real = 1; phase = nls_pkg::P_EXPD;
                end else post_plain();
            end
            nls_pkg::P_EXPS: begin
                if (c_dig(c)) begin
                    take_sure(); had_real = 1; phase = nls_pkg::P_EXPD;
                end else post_plain();
            end
            nls_pkg::P_EXPD: begin
                if (c_dig(c) || c == "_") take_sure();
                else post_plain();
            end
            nls_pkg::P_TS1: begin
                if (sfx0 != "s" && c == "s") begin take(); phase = nls_pkg::P_TS2; end
                else if (sfx0 == "s" && c_bnd(c)) post(nls_pkg::K_TIME, 0, tok_len);
                else post_plain();
            end
            nls_pkg::P_TS2: begin
                if (c_bnd(c)) post(nls_pkg::K_TIME, 0, tok_len);
                else post_plain();
            end
            default: phase = nls_pkg::P_IDLE;
        endcase
    endfunction

    // close a pending token when the source runs out
    function void close_token();
        case (phase)
            nls_pkg::P_UU: post(nls_pkg::K_UU, 0, tok_len);
            nls_pkg::P_TS1: begin
                if (sfx0 == "s") post(nls_pkg::K_TIME, 0, tok_len);
                else post_plain();
            end
            nls_pkg::P_TS2: post(nls_pkg::K_TIME, 0, tok_len);
            nls_pkg::P_BASE: begin
                flags[nls_pkg::F_MISS] = 1;
                post_based();
            end
            nls_pkg::P_VAL: post_based();
            nls_pkg::P_IDLE: ;
            default: post_plain();
        endcase
    endfunction

    function void accept_byte(nls_pkg::t_item it);
        produced = 0;
        if (it.start) begin
            clear_token();
            if (it.c == "'") begin
                take();
                phase = nls_pkg::P_UU;
            end else begin
                phase = nls_pkg::P_DIG;
                scan_byte(it.c);
            end
        end else if (phase != nls_pkg::P_IDLE) begin
            scan_byte(it.c);
        end else begin
            return;
        end
        if (!produced && it.eos && phase != nls_pkg::P_IDLE) close_token();
        if (produced) expected_tokens.push_back(next_res);
    endfunction

    task automatic compare_token(nls_pkg::t_res got);
        nls_pkg::t_res want;
        if (expected_tokens.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %p", $time, got);
            o_mismatches++;
            return;
        end
        want = expected_tokens.pop_front();
        if (got.kind !== want.kind) begin
            $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
            o_mismatches++;
        end
        if (got.based !== want.based) begin
            $display("%0t: based expected %0d actual %0d", $time, want.based, got.based);
            o_mismatches++;
        end
        if (got.len !== want.len) begin
            $display("%0t: length expected %0d actual %0d", $time, want.len, got.len);
            o_mismatches++;
        end
        if (got.err !== want.err) begin
            $display("%0t: errors expected %b actual %b", $time, want.err, got.err);
            o_mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_mismatches = 0;
            phase = nls_pkg::P_IDLE;
            clear_token();
            expected_tokens.delete();
        end else begin
            if (mon_in.valid && mon_in.ready) accept_byte(mon_in.data);
            if (mon_out.valid && mon_out.ready) compare_token(mon_out.data);
        end
        o_outstanding <= expected_tokens.size();
    end
endmodule

[test/tb.sv]
`timescale 1ns / 100ps
// Top of the number literal scanner testbench: clock, reset, byte stimulus,
// result backpressure and verdict. Depends on nls_pkg, nls_if, nls_scoreboard.
module tb;
    localparam int CYCLE_LIMIT = 600000;
    localparam int RANDOM_TOKENS = 140;  // random tokens after the directed set
    localparam int CALM_TOKENS = 25;     // tail of the run with no idling

    logic i_clk = 0;
    logic i_rst_n = 0;
    int   mismatches, outstanding;
    int   cycles = 0;
    bit   calm = 0;
    int   stall_left = 0;
    byte unsigned tok[$];

    nls_if #(.T(nls_pkg::t_item)) in_if ();
    nls_if #(.T(nls_pkg::t_res))  out_if ();

    hdl_number_literal_scanner_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_if),
        .out_ch  (out_if)
    );

    nls_scoreboard sb (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .mon_in        (in_if),
        .mon_out       (out_if),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side: random stall bursts, none in the calm tail
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_if.ready <= 0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 12);
            out_if.ready <= 0;
        end else begin
            out_if.ready <= 1;
        end
    end

    // one byte transfer, with an occasional idle gap first
    task automatic send_byte(byte unsigned c, bit start, bit eos);
        nls_pkg::t_item it;
        if (!calm && $urandom_range(0, 7) == 0) begin
            in_if.valid <= 0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        it = '0;
        it.c = c;
        it.start = start;
        it.eos = eos;
        in_if.valid <= 1;
        in_if.data  <= it;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
    endtask

    // sends the token buffer; first byte carries the start bit
    task automatic send_tok(bit eos_last);
        for (int i = 0; i < tok.size(); i++)
            send_byte(tok[i], i == 0, eos_last && i == tok.size() - 1);
        tok.delete();
    endtask

    task automatic put(string s);
        for (int i = 0; i < s.len(); i++) tok.push_back(s[i]);
    endtask

    task automatic put_digits(int n, bit unders);
        for (int i = 0; i < n; i++)
            tok.push_back((unders && i > 0 && $urandom_range(0, 5) == 0) ? "_"
                          : 8'("0" + $urandom_range(0, 9)));
    endtask

    task automatic put_pick(string pool, int n);
        for (int i = 0; i < n; i++) tok.push_back(pool[$urandom_range(0, pool.len() - 1)]);
    endtask

    task automatic directed(string s, bit eos_last);
        put(s);
        send_tok(eos_last);
    endtask

    // mostly well-formed literals with random content, some broken ones and noise
    task automatic random_token();
        string sfx[6] = '{"s", "ms", "us", "ns", "ps", "fs"};
        case ($urandom_range(0, 11))
            0: put_digits($urandom_range(1, 8), 1);
            1: begin
                put_digits($urandom_range(1, 4), 1);
                put(".");
                put_digits($urandom_range(1, 4), 1);
            end
            2: begin
                put_digits($urandom_range(1, 3), 0);
                if ($urandom_range(0, 1)) begin put("."); put_digits(2, 0); end
                put_pick("eE", 1);
                if ($urandom_range(0, 1)) put_pick("+-", 1);
                put_digits($urandom_range(0, 3), 1);
            end
            3: begin
                put_digits($urandom_range(1, 3), 0);
                if ($urandom_range(0, 2) == 0) begin put("."); put_digits(1, 0); end
                put(sfx[$urandom_range(0, 5)]);
            end
            4: begin
                put("'");
                put_pick("01xzXZ?a ", 1);
            end
            5, 6: begin
                if ($urandom_range(0, 3) != 0) put_digits($urandom_range(1, 2), 0);
                if ($urandom_range(0, 3) == 0) put_pick(" \t", $urandom_range(1, 2));
                put("'");
                if ($urandom_range(0, 2) == 0) put_pick("sS", 1);
                if ($urandom_range(0, 5) == 0) put(" ");
                put_pick("bBoOdDhH", 1);
                if ($urandom_range(0, 3) == 0) put(" ");
                put_pick("0123456789abcdefABCDEFxzXZ?_gG",
                         $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6));
            end
            7: begin
                put("'");
                put_pick("bodh s+-_.q", $urandom_range(1, 4));
            end
            8: begin
                put_digits($urandom_range(1, 2), 0);
                put_pick("mnsupfeE._", $urandom_range(1, 3));
            end
            9: put_pick("0123456789.eE+-_' sbdhx", $urandom_range(1, 6));
            10: tok.push_back(8'($urandom_range(0, 255)));
            default: begin
                put_digits(1, 0);
                for (int i = 0; i < $urandom_range(1, 4); i++)
                    tok.push_back(8'($urandom_range(0, 255)));
            end
        endcase
        // rare long literal to hit length saturation
        if ($urandom_range(0, 60) == 0) put_digits($urandom_range(250, 300), 0);
        // terminator: usually a delimiter, sometimes any byte, sometimes
        // nothing so that the next start bit abandons the token
        case ($urandom_range(0, 7))
            0, 1, 2: put_pick(" ;,)\n+", 1);
            3, 4:    tok.push_back(8'($urandom_range(0, 255)));
            5:       ;
            default: put_pick(" ;", 1);
        endcase
        send_tok($urandom_range(0, 5) == 0);
        // stray bytes between tokens, mostly ignored by an idle scanner
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 0, 0);
    endtask

    initial begin
        in_if.valid <= 0;
        in_if.data  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        directed("0 ", 0);
        directed("1_234;", 0);
        directed("3.14 ", 0);
        directed("2.5e+10;", 0);
        directed("1E3 ", 0);
        directed("1.e", 1);
        directed("10ns ", 0);
        directed("5s;", 0);
        directed("7ms_ ", 0);
        directed("'1 ", 0);
        directed("'z", 1);
        directed("8'hFF ", 0);
        directed("4 'sb 1010 ", 0);
        directed("'d 12x ", 0);
        directed("8'h  ;", 0);
        directed("8'h-1 ", 0);
        directed("8'b_01 ", 0);
        directed("8'o79 ", 0);
        directed("'d?5 ", 0);
        directed("'dz ", 0);
        directed("16'h", 1);
        directed("a9 ", 0);
        directed("12", 0);           // left pending, abandoned by the next start
        directed("99us", 1);
        put_digits(300, 0);
        directed(" ", 0);
        send_byte(8'hff, 0, 0);       // non-start byte, ends the pending token

        for (int n = 0; n < RANDOM_TOKENS; n++) begin
            if (n == RANDOM_TOKENS - CALM_TOKENS) calm = 1;
            random_token();
        end
        // start a final token that abandons any open one and ends the source
        send_byte(" ", 1, 1);
        in_if.valid <= 0;

        while (outstanding != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
